// File: rtl/bv_pkg.sv
// Shared types and constants of the barometric variometer.
// Used by bv_div and barometric_variometer; depends on nothing else.
`default_nettype none
package bv_pkg;

    localparam int AVERAGE_LENGTH = 8;
    localparam int IDX_W = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;
    localparam int SUM_W = 21 + $clog2(AVERAGE_LENGTH) + 1;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 24;

    localparam logic [29:0] EXP_Q32 = 30'd817173363;
    localparam logic [29:0] ALT_MAX_MAG = 30'd1000000;
    localparam logic [29:0] ALT_MIN_MAG = 30'd100000;
    localparam logic [47:0] VS_MAX_MAG = 48'd100000;
    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [6:0] TEMP_SCALE = 7'd125;
    localparam logic [30:0] ALT_RECIP = 31'd1321528399;

    localparam logic [1:0] REG_P0 = 2'd0;
    localparam logic [1:0] REG_T0 = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    typedef enum logic [4:0] {
        ST_ROOT_LOAD,
        ST_ROOT_ITER,
        ST_IDLE,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_TAKE,
        ST_Z_HI,
        ST_Z_LO,
        ST_Z_SUM,
        ST_EXP_MUL,
        ST_EXP_TAKE,
        ST_SHIFT,
        ST_ALT_T,
        ST_ALT_LO,
        ST_ALT_HI,
        ST_ALT_SUM,
        ST_ALT_FIN,
        ST_PRIME,
        ST_RING,
        ST_AVG_START,
        ST_VS_MUL,
        ST_VS_START,
        ST_VS_WAIT,
        ST_OUT
    } bv_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/bv_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bv_pkg for the request and response types.
`default_nettype none
module bv_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bv_pkg::div_req_t req,
    output bv_pkg::div_rsp_t      rsp
);
    import bv_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [5:0]           step_reg, step_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    always_comb begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next = '0;
            quo_next = req.dividend;
            den_next = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// File: rtl/barometric_variometer.sv
// Top level of the barometric variometer: sequencer, shared multiplier, ring filter.
// Depends on bv_pkg and bv_div.
//
// Each request on the s_ channel carries one pressure sample (s_tdata) and a
// command flag (s_tuser, 1 primes the filter). The block turns the sample into
// an altitude with the standard-atmosphere formula, smooths it with a ring
// moving average and returns one m_ request with the smoothed altitude and the
// vertical speed. Configuration writes on cfg_* take effect at once.
// After reset the block first builds its table of roots of two, 32 roots of
// 32 steps each plus a load step, with s_tready low. A sample takes longest
// for low pressures or a zero reference pressure: the two base-2 logarithms
// and the exponent loop each run through the single shared 32x32 multiplier,
// and the vertical-speed division goes through the bit-serial divider.
// The division by 13 is a reciprocal multiplication and the average a shift.
// A prime request replaces the average and the division by one step per ring
// entry, which writes the altitude into it; a zero period skips the division.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so the next sample is taken while it waits; if the
// receiver still stalls when the next result is ready, the sequencer holds.
`default_nettype none
module barometric_variometer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [24:0] pressure_q8
    input  wire logic        s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [20:0] altitude_cm, [38:21] vertical_speed_cm_s
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_wr_data
);
    import bv_pkg::*;

    bv_state_t state_reg, state_next;

    logic [16:0] p0_reg;
    logic [15:0] t0_reg;
    logic [23:0] period_reg;

    logic [31:0] ctab_reg [32];
    logic [32:0] cprev_reg;
    logic [4:0]  k_reg;
    logic [63:0] root_v_reg;
    logic [63:0] root_res_reg;

    logic        cmd_reg;
    logic [24:0] p_reg;
    logic        which_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] m_reg;
    logic [4:0]  msb_reg;
    logic [31:0] frac_reg;
    logic [37:0] lp_reg;
    logic [39:0] mag_reg;
    logic        neg_reg;
    logic [63:0] acc_reg;
    logic [39:0] z_reg;
    logic [31:0] y_reg;
    logic [39:0] dmag_reg;
    logic        dneg_reg;
    logic [22:0] t_reg;
    logic [63:0] prod_reg;

    logic signed [20:0]      alt_reg;
    logic signed [20:0]      ring_reg [AVERAGE_LENGTH];
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        fill_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [20:0]      cur_reg;
    logic signed [20:0]      prev_reg;
    logic signed [21:0]      diff_reg;
    logic signed [17:0]      vs_reg;

    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    logic [31:0] mul_a, mul_b;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    bv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Combinational helpers.
    logic [63:0] root_bit, root_sum, root_res_next;
    logic [32:0] sq_top;
    logic [31:0] sq_m_next;
    logic [31:0] sq_frac_next;
    logic [37:0] log_val;
    logic signed [40:0] lr;
    logic [63:0] z_sum;
    logic [39:0] zmag;
    logic signed [3:0] n_int;
    logic [3:0]  shamt;
    logic [39:0] ys;
    logic [63:0] q_alt;
    logic [63:0] q_round;
    logic [29:0] alt_quo;
    logic [SUM_W-1:0] sum_mag;
    logic [SUM_W-1:0] avg_mag;
    logic [20:0] diff_mag;
    logic signed [21:0] diff_now;
    logic [IDX_W-1:0] idx_inc;

    always_comb begin
        root_bit = 64'd1 << (6'd62 - {cnt_reg, 1'b0});
        root_sum = root_res_reg + root_bit;
        if (root_v_reg >= root_sum) begin
            root_res_next = (root_res_reg >> 1) + root_bit;
        end else begin
            root_res_next = root_res_reg >> 1;
        end
        sq_top = prod_reg[63:31];
        sq_m_next = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
        sq_frac_next = {frac_reg[30:0], sq_top[32]};
        log_val = {msb_reg, 1'b0, sq_frac_next};
        log_val[37:32] = {1'b0, msb_reg};
        lr = $signed({3'b0, lp_reg}) - $signed({3'b0, log_val})
             - 41'sd34359738368;
        z_sum = acc_reg + (prod_reg >> 16);
        zmag = z_sum[55:16];
        n_int = $signed(z_reg[35:32]);
        shamt = 4'(-n_int);
        if (n_int[3]) begin
            ys = {8'b0, y_reg} >> shamt;
        end else begin
            ys = {8'b0, y_reg} << n_int[2:0];
        end
        q_alt = acc_reg + {prod_reg[31:0], 32'b0};
        q_round = q_alt + (64'd13 << 26);
        alt_quo = prod_reg[63:34];
        sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        avg_mag = (sum_mag + SUM_W'(AVERAGE_LENGTH / 2)) / SUM_W'(AVERAGE_LENGTH);
        diff_now = $signed({cur_reg[20], cur_reg}) - $signed({prev_reg[20], prev_reg});
        diff_mag = diff_now[21] ? 21'(-diff_now) : diff_now[20:0];
        idx_inc = (idx_reg == IDX_W'(AVERAGE_LENGTH - 1)) ? '0 : IDX_W'(idx_reg + 1'b1);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ROOT_LOAD: state_next = ST_ROOT_ITER;
            ST_ROOT_ITER: begin
                if (cnt_reg == 5'd31) begin
                    state_next = (k_reg == 5'd31) ? ST_IDLE : ST_ROOT_LOAD;
                end
            end
            ST_IDLE:      if (s_tvalid) state_next = ST_NORM;
            ST_NORM:      if (m_reg[31]) state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_SQ_TAKE;
            ST_SQ_TAKE: begin
                if (cnt_reg == 5'd31) begin
                    state_next = which_reg ? ST_Z_HI : ST_NORM;
                end else begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_Z_HI:      state_next = ST_Z_LO;
            ST_Z_LO:      state_next = ST_Z_SUM;
            ST_Z_SUM:     state_next = ST_EXP_MUL;
            ST_EXP_MUL:   state_next = ST_EXP_TAKE;
            ST_EXP_TAKE:  state_next = (cnt_reg == 5'd31) ? ST_SHIFT : ST_EXP_MUL;
            ST_SHIFT:     state_next = ST_ALT_T;
            ST_ALT_T:     state_next = ST_ALT_LO;
            ST_ALT_LO:    state_next = ST_ALT_HI;
            ST_ALT_HI:    state_next = ST_ALT_SUM;
            ST_ALT_SUM:   state_next = ST_ALT_FIN;
            ST_ALT_FIN:   state_next = cmd_reg ? ST_PRIME : ST_RING;
            ST_PRIME: begin
                if (fill_reg == IDX_W'(AVERAGE_LENGTH - 1)) state_next = ST_OUT;
            end
            ST_RING:      state_next = ST_AVG_START;
            ST_AVG_START: state_next = ST_VS_MUL;
            ST_VS_MUL:    state_next = ST_VS_START;
            ST_VS_START:  state_next = (period_reg == '0) ? ST_OUT : ST_VS_WAIT;
            ST_VS_WAIT:   if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:       if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: multiplier operands, divider requests, ready.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_req.start = 1'b0;
        div_req.dividend = '0;
        div_req.divisor = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SQ_MUL: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_Z_HI: begin
                mul_a = {8'b0, mag_reg[39:16]};
                mul_b = {2'b0, EXP_Q32};
            end
            ST_Z_LO: begin
                mul_a = {16'b0, mag_reg[15:0]};
                mul_b = {2'b0, EXP_Q32};
            end
            ST_EXP_MUL: begin
                mul_a = y_reg;
                mul_b = ctab_reg[cnt_reg];
            end
            ST_ALT_T: begin
                mul_a = {16'b0, t0_reg};
                mul_b = {25'b0, TEMP_SCALE};
            end
            ST_ALT_LO: begin
                mul_a = dmag_reg[31:0];
                mul_b = {9'b0, prod_reg[22:0]};
            end
            ST_ALT_HI: begin
                mul_a = {24'b0, dmag_reg[39:32]};
                mul_b = {9'b0, t_reg};
            end
            ST_ALT_SUM: begin
                mul_a = q_round[58:27];
                mul_b = {1'b0, ALT_RECIP};
            end
            ST_VS_MUL: begin
                mul_a = {11'b0, diff_mag};
                mul_b = {12'b0, US_PER_S};
            end
            ST_VS_START: begin
                div_req.start = period_reg != '0;
                div_req.dividend = DIV_NUM_W'(prod_reg[41:0]) + DIV_NUM_W'(period_reg >> 1);
                div_req.divisor = period_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_reg <= 17'd101325;
            t0_reg <= 16'd28815;
            period_reg <= 24'd100000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_P0:     p0_reg <= cfg_wr_data[16:0];
                REG_T0:     t0_reg <= cfg_wr_data[15:0];
                REG_PERIOD: period_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ROOT_LOAD;
            k_reg <= '0;
            cprev_reg <= 33'h1_0000_0000;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            sum_reg <= '0;
            cur_reg <= '0;
            prev_reg <= '0;
            for (int i = 0; i < AVERAGE_LENGTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_ROOT_ITER: begin
                    if (cnt_reg == 5'd31) begin
                        cprev_reg <= root_res_next[32:0];
                        k_reg <= k_reg + 5'd1;
                    end
                end
                ST_PRIME: begin
                    ring_reg[fill_reg] <= alt_reg;
                    sum_reg <= sum_reg + SUM_W'(alt_reg);
                    cur_reg <= alt_reg;
                    prev_reg <= alt_reg;
                end
                ST_ALT_FIN: if (cmd_reg) sum_reg <= '0;
                ST_RING: begin
                    prev_reg <= cur_reg;
                    sum_reg <= sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(alt_reg);
                    ring_reg[idx_reg] <= alt_reg;
                    idx_reg <= idx_inc;
                end
                ST_AVG_START: begin
                    cur_reg <= sum_reg[SUM_W-1] ? -$signed(avg_mag[20:0])
                                                : $signed(avg_mag[20:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_ROOT_LOAD: begin
                root_v_reg <= {cprev_reg, 31'b0};
                root_res_reg <= '0;
                cnt_reg <= '0;
            end
            ST_ROOT_ITER: begin
                if (root_v_reg >= root_sum) root_v_reg <= root_v_reg - root_sum;
                root_res_reg <= root_res_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) ctab_reg[k_reg] <= root_res_next[31:0];
            end
            ST_IDLE: begin
                cmd_reg <= s_tuser;
                p_reg <= (s_tdata[24:0] == '0) ? 25'd1 : s_tdata[24:0];
                m_reg <= (s_tdata[24:0] == '0) ? 32'd1 : {7'b0, s_tdata[24:0]};
                which_reg <= 1'b0;
                cnt_reg <= '0;
            end
            ST_NORM: begin
                if (m_reg[31]) begin
                    msb_reg <= 5'd31 - cnt_reg;
                    frac_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    m_reg <= {m_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            ST_SQ_TAKE: begin
                m_reg <= sq_m_next;
                frac_reg <= sq_frac_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    if (!which_reg) begin
                        lp_reg <= log_val;
                        which_reg <= 1'b1;
                        m_reg <= (p0_reg == '0) ? 32'd1 : {15'b0, p0_reg};
                    end else begin
                        neg_reg <= lr[40];
                        mag_reg <= lr[40] ? 40'(-lr) : lr[39:0];
                    end
                end
            end
            ST_Z_LO: acc_reg <= prod_reg;
            ST_Z_SUM: begin
                z_reg <= neg_reg ? 40'(-zmag) : zmag;
                y_reg <= 32'h8000_0000;
                cnt_reg <= '0;
            end
            ST_EXP_TAKE: begin
                if (z_reg[5'd31 - cnt_reg]) y_reg <= prod_reg[62:31];
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_SHIFT: begin
                dneg_reg <= ys > 40'h80000000;
                dmag_reg <= (ys > 40'h80000000) ? (ys - 40'h80000000) : (40'h80000000 - ys);
            end
            ST_ALT_LO: t_reg <= prod_reg[22:0];
            ST_ALT_HI: acc_reg <= prod_reg;
            ST_ALT_FIN: begin
                if (!dneg_reg) begin
                    alt_reg <= (alt_quo > ALT_MAX_MAG) ? 21'sd1000000
                                                       : $signed(alt_quo[20:0]);
                end else begin
                    alt_reg <= (alt_quo > ALT_MIN_MAG) ? -21'sd100000
                                                       : -$signed(alt_quo[20:0]);
                end
                fill_reg <= '0;
            end
            ST_PRIME: begin
                fill_reg <= IDX_W'(fill_reg + 1'b1);
                vs_reg <= '0;
            end
            ST_VS_MUL: diff_reg <= diff_now;
            ST_VS_START: begin
                if (period_reg == '0) begin
                    if (diff_reg == '0) begin
                        vs_reg <= '0;
                    end else begin
                        vs_reg <= diff_reg[21] ? -18'sd100000 : 18'sd100000;
                    end
                end
            end
            ST_VS_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > VS_MAX_MAG) begin
                        vs_reg <= diff_reg[21] ? -18'sd100000 : 18'sd100000;
                    end else begin
                        vs_reg <= diff_reg[21] ? -$signed(div_rsp.quotient[17:0])
                                               : $signed(div_rsp.quotient[17:0]);
                    end
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_reg <= {1'b0, vs_reg, cur_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule
`default_nettype wire

// File: rtl/bv_checker.sv
// Port-level checks of the barometric variometer, bound to the top level.
// Depends only on the ports of barometric_variometer.
`default_nettype none
module bv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result request changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while one is in work");

    a_alt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[20:0]) >= -21'sd100000)
                  && ($signed(m_tdata[20:0]) <= 21'sd1000000))
        else $error("altitude outside its range");

    a_vs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[38:21]) >= -18'sd100000)
                  && ($signed(m_tdata[38:21]) <= 18'sd100000) && !m_tdata[39])
        else $error("vertical speed outside its range");

endmodule

bind barometric_variometer bv_checker u_bv_checker (.*);
`default_nettype wire
